// File: src/fpls_pkg.sv
`default_nettype none
package fpls_pkg;

  // Window depth and field widths
  localparam int PATTERN_MAX = 32;
  localparam int DATA_W      = 8;
  localparam int COUNT_W     = 32;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int PAT_WORDS   = 4;
  localparam int PAT_BYTES   = PAT_WORDS * CFG_W / DATA_W;
  localparam int PAT_IDX_W   = $clog2(PAT_BYTES);
  localparam int LEN_W       = 6;
  localparam int FILL_W      = $clog2(PATTERN_MAX + 1);
  localparam int CMP_W       = (FILL_W > LEN_W) ? FILL_W : LEN_W;

  localparam logic [DATA_W-1:0]  NEWLINE_BYTE = 8'd10;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_WORD0  = 3'd0,
    REG_PATTERN_WORD1  = 3'd1,
    REG_PATTERN_WORD2  = 3'd2,
    REG_PATTERN_WORD3  = 3'd3,
    REG_PATTERN_LENGTH = 3'd4,
    REG_CASE_SENSITIVE = 3'd5
  } cfg_reg_t;

  // One text byte on its way to the report stage
  typedef struct packed {
    logic               newline;
    logic               fill_ok;
    logic [COUNT_W-1:0] line;
    logic [COUNT_W-1:0] offset;
  } fpls_item_t;

  // Fold a-z to A-Z when enabled
  function automatic logic [DATA_W-1:0] fold_byte(input logic [DATA_W-1:0] b,
                                                  input logic en);
    logic [DATA_W-1:0] r;
    r = b;
    if (en && b >= 8'd97 && b <= 8'd122) begin
      r = b - 8'd32;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/fpls_if.sv
`default_nettype none
interface fpls_byte_if;
  import fpls_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface fpls_match_if;
  import fpls_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] line_number;
  logic [COUNT_W-1:0] match_end_offset;

  modport source (output valid, output line_number, output match_end_offset, input ready);
  modport sink   (input valid, input line_number, input match_end_offset, output ready);
endinterface
`default_nettype wire

// File: src/fpls_cell.sv
`default_nettype none
module fpls_cell (
  input  wire logic                      clk,
  input  wire logic                      load,
  input  wire logic [fpls_pkg::DATA_W-1:0] din,
  input  wire logic [fpls_pkg::DATA_W-1:0] pat_byte,
  input  wire logic                      in_use,
  input  wire logic                      fold_en,
  output logic      [fpls_pkg::DATA_W-1:0] q,
  output logic                           eq
);
  import fpls_pkg::*;

  logic [DATA_W-1:0] byte_r;
  logic              eq_r;
  logic              eq_nxt;

  // Compare the byte this cell takes on against its pattern byte
  assign eq_nxt = !in_use || (fold_byte(din, fold_en) == fold_byte(pat_byte, fold_en));

  // Shift the window by one cell on every transaction
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= din;
      eq_r   <= eq_nxt;
    end
  end

  assign q  = byte_r;
  assign eq = eq_r;

endmodule
`default_nettype wire

// File: src/fpls_report.sv
`default_nettype none
module fpls_report (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load,
  input  wire fpls_pkg::fpls_item_t item,
  input  wire logic                 eq_all,
  output logic                      take_ok,
  fpls_match_if.source              out_ch
);
  import fpls_pkg::*;

  logic               s2_v_r, s2_v_nxt;
  fpls_item_t         item_r;
  logic               rep_r, rep_nxt;
  logic               out_v_r;
  logic [COUNT_W-1:0] out_line_r;
  logic [COUNT_W-1:0] out_off_r;
  logic               rep_eff;
  logic               hit;
  logic               out_free;
  logic               s2_go;

  // A newline opens a fresh line with its report unused
  assign rep_eff  = item_r.newline ? 1'b0 : rep_r;
  assign hit      = s2_v_r && item_r.fill_ok && eq_all && !rep_eff;
  assign out_free = !out_v_r || out_ch.ready;
  assign s2_go    = !s2_v_r || !hit || out_free;
  assign take_ok  = s2_go;

  always_comb begin
    s2_v_nxt = load || (s2_v_r && !s2_go);
    rep_nxt  = rep_r;
    if (s2_v_r && s2_go) begin
      rep_nxt = hit ? 1'b1 : rep_eff;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      rep_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s2_v_r <= s2_v_nxt;
      rep_r  <= rep_nxt;
      if (hit && s2_go) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Hold the item and the result payload
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item;
    end
    if (hit && s2_go) begin
      out_line_r <= item_r.line;
      out_off_r  <= item_r.offset;
    end
  end

  assign out_ch.valid            = out_v_r;
  assign out_ch.line_number      = out_line_r;
  assign out_ch.match_end_offset = out_off_r;

endmodule
`default_nettype wire

// File: src/fixed_pattern_line_search_top.sv
// Fixed pattern search over a byte stream, reporting once per line.
//
// in_ch carries one text byte per transaction (valid/ready). out_ch carries
// one result per reported match: the 0-based line number and the offset just
// past the match, both saturating at 2^32-1. At most one result per line; a
// pattern that ends in a newline reports on the new line.
// The configuration port writes the pattern words, the length and the case
// mode with cfg_we, cfg_index and cfg_data; write it only while the block is
// idle.
// Throughput: one byte per cycle unless a result waits in the report stage.
// Every window cell compares its byte with the pattern in parallel in the
// cycle it is shifted, so the row of cells sets the rate. A byte accepted
// into the window sits in the report stage, and its result enters the
// output register from there.
// When out_ch stalls, the output register holds its result. Bytes that yield
// no result keep flowing; the first byte that yields one waits in the report
// stage and in_ch.ready stays low until the held result leaves.
// Reset (rst_n low at a clock edge) clears window fill, counters, line state
// and configuration (length 1, case folding on, pattern zero).
`default_nettype none
module fixed_pattern_line_search_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  fpls_byte_if.sink                           in_ch,
  fpls_match_if.source                        out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [fpls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fpls_pkg::CFG_W-1:0]     cfg_data
);
  import fpls_pkg::*;

  logic [CFG_W-1:0]   pattern_word_r [PAT_WORDS];
  logic [LEN_W-1:0]   len_r;
  logic               case_r;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [COUNT_W-1:0] byte_cnt_r, byte_cnt_nxt;
  logic [COUNT_W-1:0] line_cnt_r, line_cnt_nxt;

  logic [DATA_W-1:0]  pat_bytes [PAT_BYTES];
  logic [DATA_W-1:0]  win       [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] eq_bits;
  logic [CMP_W-1:0]   len_ext;
  logic [CMP_W-1:0]   eff_len;
  logic               fold_en;
  logic               accept;
  logic               take_ok;
  logic               is_nl;
  fpls_item_t         item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < PAT_WORDS; w++) begin
        pattern_word_r[w] <= '0;
      end
      len_r  <= LEN_W'(1);
      case_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PATTERN_WORD0:  pattern_word_r[0] <= cfg_data;
        REG_PATTERN_WORD1:  pattern_word_r[1] <= cfg_data;
        REG_PATTERN_WORD2:  pattern_word_r[2] <= cfg_data;
        REG_PATTERN_WORD3:  pattern_word_r[3] <= cfg_data;
        REG_PATTERN_LENGTH: len_r  <= cfg_data[LEN_W-1:0];
        REG_CASE_SENSITIVE: case_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Split the pattern words into bytes, byte 0 lowest
  for (genvar b = 0; b < PAT_BYTES; b++) begin : g_pat
    assign pat_bytes[b] = pattern_word_r[b / 8][(b % 8) * DATA_W +: DATA_W];
  end

  // Clamp the length to the window depth
  assign len_ext = CMP_W'(len_r);
  assign eff_len = (len_ext > CMP_W'(PATTERN_MAX)) ? CMP_W'(PATTERN_MAX) : len_ext;
  assign fold_en = !case_r;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = take_ok;
  assign is_nl        = (in_ch.data_byte == NEWLINE_BYTE);

  // Advance fill and counters, saturating
  always_comb begin
    fill_nxt     = (fill_r < FILL_W'(PATTERN_MAX)) ? fill_r + FILL_W'(1) : fill_r;
    byte_cnt_nxt = (byte_cnt_r != COUNT_MAX) ? byte_cnt_r + COUNT_W'(1) : byte_cnt_r;
    line_cnt_nxt = line_cnt_r;
    if (is_nl && line_cnt_r != COUNT_MAX) begin
      line_cnt_nxt = line_cnt_r + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      byte_cnt_r <= '0;
      line_cnt_r <= '0;
    end else if (accept) begin
      fill_r     <= fill_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      line_cnt_r <= line_cnt_nxt;
    end
  end

  assign item.newline = is_nl;
  assign item.fill_ok = (eff_len != '0) && (CMP_W'(fill_nxt) >= eff_len);
  assign item.line    = line_cnt_nxt;
  assign item.offset  = byte_cnt_nxt;

  // Row of window cells, newest byte in cell 0
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic [DATA_W-1:0] din;
    logic [CMP_W-1:0]  idx;
    logic [DATA_W-1:0] pat;
    logic              in_use;

    if (k == 0) begin : g_head
      assign din = in_ch.data_byte;
    end else begin : g_link
      assign din = win[k-1];
    end

    assign in_use = CMP_W'(k) < eff_len;
    assign idx    = eff_len - CMP_W'(k) - CMP_W'(1);
    assign pat    = (idx < CMP_W'(PAT_BYTES)) ? pat_bytes[idx[PAT_IDX_W-1:0]] : '0;

    fpls_cell u_cell (
      .clk      (clk),
      .load     (accept),
      .din      (din),
      .pat_byte (pat),
      .in_use   (in_use),
      .fold_en  (fold_en),
      .q        (win[k]),
      .eq       (eq_bits[k])
    );
  end

  fpls_report u_report (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (accept),
    .item    (item),
    .eq_all  (&eq_bits),
    .take_ok (take_ok),
    .out_ch  (out_ch)
  );

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(PATTERN_MAX))
    else $error("window fill above depth");

  a_line_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.line_number <= line_cnt_r))
    else $error("reported line ahead of line count");

  a_offset_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.match_end_offset <= byte_cnt_r
                      && out_ch.match_end_offset != '0))
    else $error("reported offset outside received bytes");

  a_new_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(accept, 2))
    else $error("result without a pending transaction");

endmodule
`default_nettype wire

// File: test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fpls_pkg::*;

  localparam int unsigned ITEM_TARGET   = 1600;
  localparam int unsigned PHASE_BYTES   = 80;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned MAX_SHOWN     = 10;
  localparam int unsigned LEN_TOP       = (1 << LEN_W) - 1;
  localparam string       LETTERS       = "aAbBzZ{@[^\n";

  typedef struct packed {
    logic [COUNT_W-1:0] line;
    logic [COUNT_W-1:0] offset;
  } report_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  cfg_reg_t           cfg_index;
  logic [CFG_W-1:0]   cfg_data;

  fpls_byte_if  in_ch ();
  fpls_match_if out_ch ();

  fixed_pattern_line_search_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Search state mirrored by the predictor
  logic [DATA_W-1:0]  win [PATTERN_MAX];
  int unsigned        win_fill;
  logic [COUNT_W-1:0] bytes_seen;
  logic [COUNT_W-1:0] lines_seen;
  bit                 line_done;
  logic [CFG_W-1:0]   pat_word [PAT_WORDS];
  logic [LEN_W-1:0]   pat_len;
  bit                 exact_case;
  report_t            pending_reports [$];

  // Run bookkeeping and traffic knobs
  int unsigned        bytes_accepted;
  int unsigned        reports_seen;
  int unsigned        settings_loaded;
  int unsigned        mismatches;
  int unsigned        cycle_count;
  int unsigned        hold_req;
  bit                 idle_on;
  logic [DATA_W-1:0]  pat_buf [PATTERN_MAX];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void reset_model();
    foreach (win[i]) win[i] = '0;
    foreach (pat_word[i]) pat_word[i] = '0;
    win_fill   = 0;
    bytes_seen = '0;
    lines_seen = '0;
    line_done  = 1'b0;
    pat_len    = LEN_W'(1);
    exact_case = 1'b0;
  endfunction

  function automatic logic [DATA_W-1:0] upper_fold(logic [DATA_W-1:0] b);
    if (!exact_case && b >= "a" && b <= "z") return b - 8'd32;
    return b;
  endfunction

  function automatic bit window_hit();
    int unsigned       n;
    logic [DATA_W-1:0] pb;
    n = 32'(pat_len);
    if (n == 0) return 1'b0;
    if (n > PATTERN_MAX) n = PATTERN_MAX;
    if (win_fill < n) return 1'b0;
    for (int i = 0; i < n; i++) begin
      pb = pat_word[i / 8][(i % 8) * 8 +: 8];
      if (upper_fold(win[n - 1 - i]) != upper_fold(pb)) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Shift one byte in, count it, then compare the window
  function automatic void scan_byte(logic [DATA_W-1:0] b);
    report_t r;
    for (int i = PATTERN_MAX - 1; i > 0; i--) win[i] = win[i - 1];
    win[0] = b;
    if (win_fill < PATTERN_MAX) win_fill++;
    if (bytes_seen != COUNT_MAX) bytes_seen++;
    if (b == NEWLINE_BYTE) begin
      if (lines_seen != COUNT_MAX) lines_seen++;
      line_done = 1'b0;
    end
    if (!line_done && window_hit()) begin
      line_done = 1'b1;
      r.line    = lines_seen;
      r.offset  = bytes_seen;
      pending_reports.push_back(r);
    end
  endfunction

  function automatic void note_error(string msg);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("ERROR: %s", msg);
  endfunction

  // Check each result transaction, then predict from each byte transaction
  always @(posedge clk) begin
    report_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        reports_seen++;
        if (pending_reports.size() == 0) begin
          note_error($sformatf("unexpected report line %0d offset %0d",
                               out_ch.line_number, out_ch.match_end_offset));
        end else begin
          want = pending_reports.pop_front();
          if (out_ch.line_number !== want.line)
            note_error($sformatf("line_number expected %0d got %0d",
                                 want.line, out_ch.line_number));
          if (out_ch.match_end_offset !== want.offset)
            note_error($sformatf("match_end_offset expected %0d got %0d",
                                 want.offset, out_ch.match_end_offset));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        bytes_accepted++;
        scan_byte(in_ch.data_byte);
      end
    end
  end

  function automatic int unsigned gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // Drive result ready: long hold on request, random stalls while idling is on
  initial begin
    int unsigned n;
    out_ch.ready <= 1'b0;
    forever begin
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Stop a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ERROR: timeout after %0d cycles, %0d reports still pending",
             cycle_count, pending_reports.size());
    $display("fixed_pattern_line_search_top regression: fail");
    $finish;
  end

  // Offer one byte and hold it until the transaction completes
  task automatic send_byte(input logic [DATA_W-1:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Drop valid and wait for every pending report plus the pipeline tail
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write enable stays high across back-to-back writes; cfg_close drops it
  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_PATTERN_WORD0:  pat_word[0] = val;
      REG_PATTERN_WORD1:  pat_word[1] = val;
      REG_PATTERN_WORD2:  pat_word[2] = val;
      REG_PATTERN_WORD3:  pat_word[3] = val;
      REG_PATTERN_LENGTH: pat_len = val[LEN_W-1:0];
      REG_CASE_SENSITIVE: exact_case = val[0];
      default: ;
    endcase
  endtask

  task automatic cfg_close();
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  function automatic void text_to_pattern(string s);
    foreach (pat_buf[i]) pat_buf[i] = '0;
    for (int i = 0; i < s.len() && i < PATTERN_MAX; i++) pat_buf[i] = s[i];
  endfunction

  task automatic load_words();
    logic [CFG_W-1:0] w [PAT_WORDS];
    for (int i = 0; i < PATTERN_MAX; i++) w[i / 8][(i % 8) * 8 +: 8] = pat_buf[i];
    cfg_write(REG_PATTERN_WORD0, w[0]);
    cfg_write(REG_PATTERN_WORD1, w[1]);
    cfg_write(REG_PATTERN_WORD2, w[2]);
    cfg_write(REG_PATTERN_WORD3, w[3]);
  endtask

  task automatic load_pattern(input int unsigned len, input bit exact);
    load_words();
    cfg_write(REG_PATTERN_LENGTH, CFG_W'(len));
    cfg_write(REG_CASE_SENSITIVE, CFG_W'(exact));
    cfg_close();
  endtask

  function automatic logic [DATA_W-1:0] pick_byte(bit wide);
    if (wide) return DATA_W'($urandom_range(0, 255));
    return LETTERS[$urandom_range(0, LETTERS.len() - 1)];
  endfunction

  // Flip letter case at random when matching folds case
  function automatic logic [DATA_W-1:0] vary_case(logic [DATA_W-1:0] b);
    if (exact_case || $urandom_range(0, 1) == 0) return b;
    if (b >= "a" && b <= "z") return b - 8'd32;
    if (b >= "A" && b <= "Z") return b + 8'd32;
    return b;
  endfunction

  // Reset pattern is all zero and the window starts empty: only the third zero reports
  task automatic test_partial_window();
    cfg_write(REG_PATTERN_LENGTH, CFG_W'(3));
    cfg_close();
    repeat (3) send_byte(8'h00);
    send_byte(NEWLINE_BYTE);
  endtask

  // Case folding is on out of reset; only words and length are written
  task automatic test_case_folding();
    wait_idle();
    text_to_pattern("ab");
    load_words();
    cfg_write(REG_PATTERN_LENGTH, CFG_W'(2));
    cfg_close();
    send_text("xAB\nAb\n");
  endtask

  task automatic test_case_exact();
    wait_idle();
    text_to_pattern("aB");
    load_pattern(2, 1'b1);
    send_text("ABabaB\n");
  endtask

  task automatic test_byte_extremes();
    wait_idle();
    text_to_pattern("");
    pat_buf[0] = 8'hFF;
    pat_buf[1] = 8'h00;
    load_pattern(2, 1'b0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(NEWLINE_BYTE);
  endtask

  // Newline-ended, overlapping occurrences each land on a fresh line
  task automatic test_newline_pattern();
    wait_idle();
    text_to_pattern("\n\n");
    load_pattern(2, 1'b0);
    send_text("x\n\n\n");
  endtask

  task automatic test_zero_length();
    wait_idle();
    text_to_pattern("");
    load_pattern(0, 1'b0);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(NEWLINE_BYTE);
    send_byte(8'h00);
  endtask

  // Hold the result side off so the block fills and stalls its input
  task automatic test_output_stall();
    wait_idle();
    idle_on = 1'b0;
    text_to_pattern("q");
    load_pattern(1, 1'b0);
    hold_req = 400;
    for (int i = 0; i < 40; i++) send_text("q\n");
  endtask

  // Phases of random settings; text mixes planted and broken occurrences, newlines and random bytes
  task automatic test_random_text();
    int unsigned start, phase_start, phase, plen, eff, r, cut;
    bit          wide;
    start = bytes_accepted;
    phase = 0;
    while (bytes_accepted - start < ITEM_TARGET) begin
      wait_idle();
      wide = ($urandom_range(0, 2) == 0);
      r = $urandom_range(0, 19);
      if (phase == 0) plen = PATTERN_MAX;
      else if (phase == 1) plen = LEN_TOP;
      else if (r == 0) plen = 0;
      else if (r < 3) plen = $urandom_range(PATTERN_MAX, LEN_TOP);
      else if (r < 6) plen = $urandom_range(9, PATTERN_MAX - 1);
      else plen = $urandom_range(1, 8);
      eff = (plen > PATTERN_MAX) ? PATTERN_MAX : plen;
      foreach (pat_buf[i]) pat_buf[i] = pick_byte(wide);
      load_pattern(plen, 1'($urandom_range(0, 1)));
      idle_on = ($urandom_range(0, 3) != 0);
      phase_start = bytes_accepted;
      while (bytes_accepted - phase_start < PHASE_BYTES) begin
        r = $urandom_range(0, 9);
        if (r < 3) begin
          cut = (r == 2) ? $urandom_range(0, eff) : eff;
          for (int i = 0; i < cut; i++) send_byte(vary_case(pat_buf[i]));
          if (r == 2) send_byte(pick_byte(wide));
        end else if (r == 3) begin
          send_byte(NEWLINE_BYTE);
        end else begin
          send_byte(pick_byte(wide));
        end
      end
      phase++;
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_PATTERN_WORD0;
    cfg_data        <= '0;
    reset_model();
    hold_req        = 0;
    idle_on         = 1'b0;
    bytes_accepted  = 0;
    reports_seen    = 0;
    settings_loaded = 0;
    mismatches      = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_partial_window();
    test_case_folding();
    test_case_exact();
    test_byte_extremes();
    test_newline_pattern();
    test_zero_length();
    test_output_stall();
    test_random_text();
    wait_idle();

    $display("Scanned %0d bytes under %0d pattern settings: lengths 0 to %0d,",
             bytes_accepted, settings_loaded, LEN_TOP);
    $display("both case modes, partial window, newline patterns, output stall; %0d reports.",
             reports_seen);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("fixed_pattern_line_search_top regression: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("fixed_pattern_line_search_top regression: fail");
    end
    $finish;
  end

endmodule

// File: fixed_pattern_line_search_top.f
src/fpls_pkg.sv
src/fpls_if.sv
src/fpls_cell.sv
src/fpls_report.sv
src/fixed_pattern_line_search_top.sv
test/tb.sv
